FILE: rtl/pmg_pkg.sv
// Shared types, constants and helpers for the Prim maze generator.
`default_nettype none
package pmg_pkg;

  localparam int MAX_W      = 32;
  localparam int MAX_H      = 32;
  localparam int X_W        = $clog2(MAX_W);
  localparam int Y_W        = $clog2(MAX_H);
  localparam int CA_W       = X_W + Y_W;
  localparam int NCELLS     = MAX_W * MAX_H;
  localparam int FS_W       = 11;
  localparam int DIM_W      = 6;
  localparam int RAND_W     = 16;
  localparam int GRID_RESET = 16;

  localparam logic       REG_GRID_W = 1'b0;
  localparam logic       REG_GRID_H = 1'b1;
  localparam logic [3:0] WALLS_ALL  = 4'hF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    CS_UNVIS = 2'd0,
    CS_FRONT = 2'd1,
    CS_MARK  = 2'd2
  } cstat_t;

  typedef enum logic [2:0] {
    AS_PTR, AS_SELF, AS_SLOT, AS_DIR, AS_RDC
  } asel_t;

  typedef enum logic [1:0] {
    WS_CLEAR, WS_MARK, WS_FRONT, WS_WALL
  } wsel_t;

  typedef enum logic [1:0] {
    FS_REM, FS_PTR1, FS_PTR2
  } fsel_t;

  typedef enum logic [1:0] {
    MS_X, MS_Y, MS_POS, MS_K
  } msel_t;

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_DISPATCH, S_ST_CLR, S_ST_MODX, S_ST_MODY,
    S_MARK_RD, S_MARK_WR, S_NB_CHK, S_NB_WR, S_POS_MOD, S_IDX, S_SHIFT,
    S_CAND, S_CAND_CHK, S_CAND_END, S_K_MOD, S_NW_RD, S_NW_WR,
    S_RD_WAIT, S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [RAND_W-1:0] rand_a;
    logic [RAND_W-1:0] rand_b;
    logic [X_W-1:0]    cell_x;
    logic [Y_W-1:0]    cell_y;
  } in_item_t;

  typedef struct packed {
    logic            status;
    logic [X_W-1:0]  from_x;
    logic [Y_W-1:0]  from_y;
    logic [1:0]      carved_dir;
    logic [FS_W-1:0] frontier_count;
    logic            done_res;
    logic [3:0]      walls;
  } out_item_t;

  typedef struct packed {
    logic  load_in;
    logic  begin_start;
    logic  set_err;
    logic  cell_rd;
    logic  cell_wr;
    asel_t asel;
    wsel_t wsel;
    logic  ptr_inc;
    logic  ptr_load_rem;
    logic  f_rd;
    fsel_t fsel;
    logic  f_shift;
    logic  f_push;
    logic  fsz_dec;
    logic  fxy_load;
    logic  slot_clr;
    logic  slot_inc;
    logic  cand_add;
    logic  mod_go;
    msel_t msel;
    logic  set_fx;
    logic  set_fy;
    logic  set_dir;
    logic  walls_load;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fsize_zero;
    logic       mod_busy;
    logic       ptr_last;
    logic       shift_more1;
    logic       shift_more2;
    logic       nbr_in;
    cstat_t     rd_stat;
    logic       slot_last;
    logic       cand_zero;
    logic       rd_in;
    logic       out_free;
  } stat_t;

  // neighbor scan order: west, east, north, south
  function automatic dir_t slot_dir(input logic [1:0] s);
    dir_t d;
    unique case (s)
      2'd0:    d = DIR_W;
      2'd1:    d = DIR_E;
      2'd2:    d = DIR_N;
      default: d = DIR_S;
    endcase
    return d;
  endfunction

  function automatic dir_t opp_dir(input dir_t d);
    return dir_t'(d + 2'd2);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/prim_maze_generator_core.sv
// Top level of the randomized Prim maze generator.
//
//   channel  dir  handshake            payload
//   in_*     in   in_valid / in_stall  in_data   (in_item_t)
//   out_*    out  out_valid / out_stall out_data (out_item_t)
//   cfg_*    in   cfg_we               cfg_idx, cfg_wdata
//
// One item at a time. A step runs two bit-serial remainders and shifts
// each frontier entry behind the removed one down by one place (the
// frontier RAM shifts one entry a cycle). A start sweeps all 1024 cells
// of the grid RAM, then runs two remainders and the mark.
// After reset the same sweep runs before the first transfer is
// taken; configuration writes are accepted throughout.
// A finished result waits in the output register; the next input transfer is
// taken while it is stalled, and only the result write of that item waits.
`default_nettype none
module prim_maze_generator_core
  import pmg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [DIM_W-1:0] cfg_wdata
);

  // command and status buses between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  pmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pmg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/pmg_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
`default_nettype none
module pmg_mod
  import pmg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [RAND_W-1:0] dividend,
  input  wire logic [FS_W-1:0]   divisor,
  output logic                   busy,
  output logic [FS_W-1:0]        rem
);

  localparam int CNT_W = $clog2(RAND_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAND_W-1:0] dvd_r;
  logic [FS_W-1:0]   div_r;
  logic [FS_W-1:0]   rem_r;
  logic [FS_W-1:0]   rem_nxt;
  logic [FS_W:0]     trial;

  always_comb begin
    trial = {rem_r, dvd_r[RAND_W-1]};
    if (trial >= {1'b0, div_r}) rem_nxt = FS_W'(trial - {1'b0, div_r});
    else rem_nxt = FS_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RAND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RAND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: rtl/pmg_dp.sv
// Datapath: grid and frontier memories, config, counters, result register.
`default_nettype none
module pmg_dp
  import pmg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire cmd_t             cmd,
  output stat_t                 st,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic [DIM_W-1:0] cfg_w_r, cfg_h_r, act_w_r, act_h_r;
  in_item_t         item_r;
  logic             started_r;
  logic [FS_W-1:0]  fsize_r;
  logic [X_W-1:0]   fx_r;
  logic [Y_W-1:0]   fy_r;
  dir_t             dir_r;
  logic [3:0]       self_mask_r;
  logic [3:0]       walls_r;
  logic             err_r;
  logic [CA_W-1:0]  ptr_r;
  logic [1:0]       slot_r;
  logic [2:0]       cand_n_r;
  dir_t             cand_dir_r [4];
  logic             out_valid_r;
  out_item_t        out_r;

  logic [5:0]       cell_mem [NCELLS];
  logic [5:0]       crd_r;
  logic [CA_W-1:0]  fr_mem [NCELLS];
  logic [CA_W-1:0]  frd_r;

  dir_t             slot_d;
  dir_t             pick_d;
  logic [CA_W-1:0]  cell_addr;
  logic [5:0]       cell_wdata;
  logic [CA_W-1:0]  f_raddr;
  logic [CA_W-1:0]  f_waddr;
  logic [CA_W-1:0]  f_wdata;
  logic [RAND_W-1:0] mod_dvd;
  logic [FS_W-1:0]  mod_div;
  logic             mod_busy;
  logic [FS_W-1:0]  mod_rem;
  out_item_t        res;

  function automatic logic nbr_ok(input dir_t d, input logic [X_W-1:0] x,
                                  input logic [Y_W-1:0] y,
                                  input logic [DIM_W-1:0] aw,
                                  input logic [DIM_W-1:0] ah);
    logic ok;
    unique case (d)
      DIR_N:   ok = (y != '0);
      DIR_E:   ok = (DIM_W'(x) + DIM_W'(1) < aw);
      DIR_S:   ok = (DIM_W'(y) + DIM_W'(1) < ah);
      default: ok = (x != '0);
    endcase
    return ok;
  endfunction

  function automatic logic [CA_W-1:0] nbr_addr(input dir_t d,
                                               input logic [X_W-1:0] x,
                                               input logic [Y_W-1:0] y);
    logic [CA_W-1:0] a;
    unique case (d)
      DIR_N:   a = {y - Y_W'(1), x};
      DIR_E:   a = {y, x + X_W'(1)};
      DIR_S:   a = {y + Y_W'(1), x};
      default: a = {y, x - X_W'(1)};
    endcase
    return a;
  endfunction

  assign slot_d = slot_dir(slot_r);
  assign pick_d = cand_dir_r[mod_rem[1:0]];

  always_comb begin
    unique case (cmd.asel)
      AS_PTR:  cell_addr = ptr_r;
      AS_SELF: cell_addr = {fy_r, fx_r};
      AS_SLOT: cell_addr = nbr_addr(slot_d, fx_r, fy_r);
      AS_DIR:  cell_addr = nbr_addr(dir_r, fx_r, fy_r);
      default: cell_addr = {item_r.cell_y, item_r.cell_x};
    endcase
  end

  always_comb begin
    unique case (cmd.wsel)
      WS_CLEAR: cell_wdata = {CS_UNVIS, WALLS_ALL};
      WS_MARK:  cell_wdata = {CS_MARK, crd_r[3:0] & ~self_mask_r};
      WS_FRONT: cell_wdata = {CS_FRONT, crd_r[3:0]};
      default:  cell_wdata = {crd_r[5:4], crd_r[3:0] & ~(4'b0001 << opp_dir(dir_r))};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_wr) cell_mem[cell_addr] <= cell_wdata;
    if (cmd.cell_rd) crd_r <= cell_mem[cell_addr];
  end

  always_comb begin
    unique case (cmd.fsel)
      FS_REM:  f_raddr = mod_rem[CA_W-1:0];
      FS_PTR1: f_raddr = ptr_r + CA_W'(1);
      default: f_raddr = ptr_r + CA_W'(2);
    endcase
    f_waddr = cmd.f_push ? fsize_r[CA_W-1:0] : ptr_r;
    f_wdata = cmd.f_push ? nbr_addr(slot_d, fx_r, fy_r) : frd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.f_push || cmd.f_shift) fr_mem[f_waddr] <= f_wdata;
    if (cmd.f_rd) frd_r <= fr_mem[f_raddr];
  end

  always_comb begin
    unique case (cmd.msel)
      MS_X: begin
        mod_dvd = item_r.rand_a;
        mod_div = FS_W'(act_w_r);
      end
      MS_Y: begin
        mod_dvd = item_r.rand_b;
        mod_div = FS_W'(act_h_r);
      end
      MS_POS: begin
        mod_dvd = item_r.rand_a;
        mod_div = fsize_r;
      end
      default: begin
        mod_dvd = item_r.rand_b;
        mod_div = FS_W'(cand_n_r);
      end
    endcase
  end

  pmg_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.mod_go),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= DIM_W'(GRID_RESET);
      cfg_h_r     <= DIM_W'(GRID_RESET);
      act_w_r     <= clamp_dim(DIM_W'(GRID_RESET), DIM_W'(MAX_W));
      act_h_r     <= clamp_dim(DIM_W'(GRID_RESET), DIM_W'(MAX_H));
      started_r   <= 1'b0;
      fsize_r     <= '0;
      ptr_r       <= '0;
      slot_r      <= '0;
      cand_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_GRID_W: cfg_w_r <= cfg_wdata;
          default:    cfg_h_r <= cfg_wdata;
        endcase
      end
      if (cmd.begin_start) begin
        act_w_r   <= clamp_dim(cfg_w_r, DIM_W'(MAX_W));
        act_h_r   <= clamp_dim(cfg_h_r, DIM_W'(MAX_H));
        started_r <= 1'b1;
        fsize_r   <= '0;
        ptr_r     <= '0;
      end else if (cmd.ptr_load_rem) begin
        ptr_r <= mod_rem[CA_W-1:0];
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + CA_W'(1);
      end
      if (cmd.f_push) fsize_r <= fsize_r + FS_W'(1);
      else if (cmd.fsz_dec) fsize_r <= fsize_r - FS_W'(1);
      if (cmd.slot_clr) slot_r <= '0;
      else if (cmd.slot_inc) slot_r <= slot_r + 2'd1;
      if (cmd.load_in) cand_n_r <= '0;
      else if (cmd.cand_add) cand_n_r <= cand_n_r + 3'd1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    res.status         = err_r;
    res.from_x         = err_r ? '0 : fx_r;
    res.from_y         = err_r ? '0 : fy_r;
    res.carved_dir     = err_r ? 2'd0 : dir_r;
    res.frontier_count = fsize_r;
    res.done_res       = started_r && (fsize_r == '0);
    res.walls          = walls_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r      <= in_data;
      fx_r        <= '0;
      fy_r        <= '0;
      dir_r       <= DIR_N;
      self_mask_r <= '0;
      walls_r     <= '0;
      err_r       <= 1'b0;
    end else begin
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.set_fx) fx_r <= mod_rem[X_W-1:0];
      if (cmd.set_fy) fy_r <= mod_rem[Y_W-1:0];
      if (cmd.fxy_load) begin
        fx_r <= frd_r[X_W-1:0];
        fy_r <= frd_r[CA_W-1:X_W];
      end
      if (cmd.set_dir) begin
        dir_r       <= pick_d;
        self_mask_r <= 4'b0001 << pick_d;
      end
      if (cmd.walls_load) walls_r <= crd_r[3:0];
    end
    if (cmd.cand_add) cand_dir_r[cand_n_r[1:0]] <= slot_d;
    if (cmd.out_load) out_r <= res;
  end

  always_comb begin
    st.op          = item_r.opcode;
    st.fsize_zero  = (fsize_r == '0);
    st.mod_busy    = mod_busy;
    st.ptr_last    = &ptr_r;
    st.shift_more1 = (FS_W'(ptr_r) + FS_W'(1) < fsize_r);
    st.shift_more2 = (FS_W'(ptr_r) + FS_W'(2) < fsize_r);
    st.nbr_in      = nbr_ok(slot_d, fx_r, fy_r, act_w_r, act_h_r);
    st.rd_stat     = cstat_t'(crd_r[5:4]);
    st.slot_last   = &slot_r;
    st.cand_zero   = (cand_n_r == '0);
    st.rd_in       = (DIM_W'(item_r.cell_x) < act_w_r) &&
                     (DIM_W'(item_r.cell_y) < act_h_r);
    st.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_mod_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_go |-> !mod_busy)
    else $error("remainder unit restarted while busy");

  a_fsz_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fsz_dec |-> fsize_r != '0)
    else $error("frontier count underflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.f_push |-> fsize_r < FS_W'(NCELLS))
    else $error("frontier list overflow");

  a_cell_port: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cell_rd |-> !cmd.cell_wr)
    else $error("grid memory read and write in the same cycle");

endmodule
`default_nettype wire

FILE: rtl/pmg_ctrl.sv
// Controller state machine: sequences clear, mark, frontier pick, carve and cell reads.
`default_nettype none
module pmg_ctrl
  import pmg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RST_CLR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_RST_CLR: begin
        cmd.cell_wr = 1'b1;
        cmd.asel    = AS_PTR;
        cmd.wsel    = WS_CLEAR;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.op)
          OP_START: begin
            cmd.begin_start = 1'b1;
            state_nxt       = S_ST_CLR;
          end
          OP_STEP: begin
            if (st.fsize_zero) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.mod_go = 1'b1;
              cmd.msel   = MS_POS;
              state_nxt  = S_POS_MOD;
            end
          end
          OP_READ: begin
            if (st.rd_in) begin
              cmd.cell_rd = 1'b1;
              cmd.asel    = AS_RDC;
              state_nxt   = S_RD_WAIT;
            end else begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end
          end
          default: begin
            cmd.set_err = 1'b1;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_ST_CLR: begin
        cmd.cell_wr = 1'b1;
        cmd.asel    = AS_PTR;
        cmd.wsel    = WS_CLEAR;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) begin
          cmd.mod_go = 1'b1;
          cmd.msel   = MS_X;
          state_nxt  = S_ST_MODX;
        end
      end
      S_ST_MODX: begin
        if (!st.mod_busy) begin
          cmd.set_fx = 1'b1;
          cmd.mod_go = 1'b1;
          cmd.msel   = MS_Y;
          state_nxt  = S_ST_MODY;
        end
      end
      S_ST_MODY: begin
        if (!st.mod_busy) begin
          cmd.set_fy = 1'b1;
          state_nxt  = S_MARK_RD;
        end
      end
      S_MARK_RD: begin
        cmd.cell_rd = 1'b1;
        cmd.asel    = AS_SELF;
        state_nxt   = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.cell_wr  = 1'b1;
        cmd.asel     = AS_SELF;
        cmd.wsel     = WS_MARK;
        cmd.slot_clr = 1'b1;
        state_nxt    = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (st.nbr_in) begin
          cmd.cell_rd = 1'b1;
          cmd.asel    = AS_SLOT;
          state_nxt   = S_NB_WR;
        end else if (st.slot_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_NB_WR: begin
        cmd.asel = AS_SLOT;
        cmd.wsel = WS_FRONT;
        if (st.rd_stat == CS_UNVIS) begin
          cmd.cell_wr = 1'b1;
          cmd.f_push  = 1'b1;
        end
        if (st.slot_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_NB_CHK;
        end
      end
      S_POS_MOD: begin
        if (!st.mod_busy) begin
          cmd.f_rd         = 1'b1;
          cmd.fsel         = FS_REM;
          cmd.ptr_load_rem = 1'b1;
          state_nxt        = S_IDX;
        end
      end
      S_IDX: begin
        cmd.fxy_load = 1'b1;
        if (st.shift_more1) begin
          cmd.f_rd  = 1'b1;
          cmd.fsel  = FS_PTR1;
          state_nxt = S_SHIFT;
        end else begin
          cmd.fsz_dec  = 1'b1;
          cmd.slot_clr = 1'b1;
          state_nxt    = S_CAND;
        end
      end
      S_SHIFT: begin
        cmd.f_shift = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (st.shift_more2) begin
          cmd.f_rd = 1'b1;
          cmd.fsel = FS_PTR2;
        end else begin
          cmd.fsz_dec  = 1'b1;
          cmd.slot_clr = 1'b1;
          state_nxt    = S_CAND;
        end
      end
      S_CAND: begin
        if (st.nbr_in) begin
          cmd.cell_rd = 1'b1;
          cmd.asel    = AS_SLOT;
          state_nxt   = S_CAND_CHK;
        end else if (st.slot_last) begin
          state_nxt = S_CAND_END;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_CAND_CHK: begin
        if (st.rd_stat == CS_MARK) cmd.cand_add = 1'b1;
        if (st.slot_last) begin
          state_nxt = S_CAND_END;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_CAND;
        end
      end
      S_CAND_END: begin
        if (st.cand_zero) begin
          state_nxt = S_MARK_RD;
        end else begin
          cmd.mod_go = 1'b1;
          cmd.msel   = MS_K;
          state_nxt  = S_K_MOD;
        end
      end
      S_K_MOD: begin
        if (!st.mod_busy) begin
          cmd.set_dir = 1'b1;
          state_nxt   = S_NW_RD;
        end
      end
      S_NW_RD: begin
        cmd.cell_rd = 1'b1;
        cmd.asel    = AS_DIR;
        state_nxt   = S_NW_WR;
      end
      S_NW_WR: begin
        cmd.cell_wr = 1'b1;
        cmd.asel    = AS_DIR;
        cmd.wsel    = WS_WALL;
        state_nxt   = S_MARK_RD;
      end
      S_RD_WAIT: begin
        cmd.walls_load = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the randomized Prim maze generator core.
`timescale 1ns / 100ps
module tb;
  import pmg_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = REG_GRID_W;
  logic [DIM_W-1:0] cfg_wdata = '0;

  prim_maze_generator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow maze: cell states, walls, ordered frontier, dimensions.
  cstat_t      shadow_stat[NCELLS];
  logic [3:0]  shadow_walls[NCELLS];
  int          frontier_q[$];
  int          reg_w = GRID_RESET, reg_h = GRID_RESET;
  int          act_w = GRID_RESET, act_h = GRID_RESET;
  bit          started = 1'b0;

  out_item_t   pending_results[$];
  int          mismatches = 0;
  int          items_sent = 0;
  longint      cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NCELLS; i++) begin
      shadow_stat[i] = CS_UNVIS;
      shadow_walls[i] = WALLS_ALL;
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls about 14% of cycles unless in a quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 14);
  end

  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void push_frontier(int x, int y);
    int idx = y * MAX_W + x;
    if (shadow_stat[idx] == CS_UNVIS) begin
      shadow_stat[idx] = CS_FRONT;
      frontier_q.insert(frontier_q.size(), idx);
    end
  endfunction

  // Mark a cell and append its unvisited W, E, N, S neighbors.
  function automatic void mark_cell(int x, int y);
    shadow_stat[y * MAX_W + x] = CS_MARK;
    if (x > 0) push_frontier(x - 1, y);
    if (x + 1 < act_w) push_frontier(x + 1, y);
    if (y > 0) push_frontier(x, y - 1);
    if (y + 1 < act_h) push_frontier(x, y + 1);
  endfunction

  function automatic bit is_marked(int x, int y);
    return shadow_stat[y * MAX_W + x] == CS_MARK;
  endfunction

  // Advance the shadow maze by one transfer and return the expected result.
  function automatic out_item_t carve_predict(in_item_t it);
    out_item_t r;
    int fx, fy, pos, idx, n, k;
    int nx[4], ny[4];
    dir_t nd[4];
    dir_t d;
    r = '0;
    fx = 0;
    fy = 0;
    d = DIR_N;
    case (op_t'(it.opcode))
      OP_START: begin
        act_w = clamp_size(reg_w, MAX_W);
        act_h = clamp_size(reg_h, MAX_H);
        for (int i = 0; i < NCELLS; i++) begin
          shadow_stat[i] = CS_UNVIS;
          shadow_walls[i] = WALLS_ALL;
        end
        frontier_q.delete();
        started = 1'b1;
        fx = int'(it.rand_a) % act_w;
        fy = int'(it.rand_b) % act_h;
        mark_cell(fx, fy);
      end
      OP_STEP: begin
        if (frontier_q.size() == 0) begin
          r.status = 1'b1;
        end else begin
          pos = int'(it.rand_a) % frontier_q.size();
          idx = frontier_q[pos];
          frontier_q.delete(pos);
          fx = idx % MAX_W;
          fy = idx / MAX_W;
          n = 0;
          if (fx > 0 && is_marked(fx - 1, fy)) begin
            nx[n] = fx - 1; ny[n] = fy; nd[n] = DIR_W; n++;
          end
          if (fx + 1 < act_w && is_marked(fx + 1, fy)) begin
            nx[n] = fx + 1; ny[n] = fy; nd[n] = DIR_E; n++;
          end
          if (fy > 0 && is_marked(fx, fy - 1)) begin
            nx[n] = fx; ny[n] = fy - 1; nd[n] = DIR_N; n++;
          end
          if (fy + 1 < act_h && is_marked(fx, fy + 1)) begin
            nx[n] = fx; ny[n] = fy + 1; nd[n] = DIR_S; n++;
          end
          if (n > 0) begin
            k = int'(it.rand_b) % n;
            d = nd[k];
            shadow_walls[fy * MAX_W + fx][d] = 1'b0;
            // opposite wall on the joined neighbor
            shadow_walls[ny[k] * MAX_W + nx[k]][(d + 2) % 4] = 1'b0;
          end
          mark_cell(fx, fy);
        end
      end
      OP_READ: begin
        if (it.cell_x < act_w && it.cell_y < act_h)
          r.walls = shadow_walls[it.cell_y * MAX_W + it.cell_x];
        else
          r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    if (!r.status) begin
      r.from_x = fx[X_W-1:0];
      r.from_y = fy[Y_W-1:0];
      r.carved_dir = d;
    end
    r.frontier_count = FS_W'(frontier_q.size());
    r.done_res = started && frontier_q.size() == 0;
    return r;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h at cycle %0d", out_data, cycles);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.from_x !== want.from_x ||
            out_data.from_y !== want.from_y ||
            out_data.carved_dir !== want.carved_dir ||
            out_data.frontier_count !== want.frontier_count ||
            out_data.done_res !== want.done_res || out_data.walls !== want.walls) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: exp st=%0d x=%0d y=%0d dir=%0d fc=%0d ",
                      "done=%0d w=%h, got st=%0d x=%0d y=%0d dir=%0d fc=%0d ",
                      "done=%0d w=%h"},
                     cycles, want.status, want.from_x, want.from_y, want.carved_dir,
                     want.frontier_count, want.done_res, want.walls,
                     out_data.status, out_data.from_x, out_data.from_y,
                     out_data.carved_dir, out_data.frontier_count, out_data.done_res,
                     out_data.walls);
        end
      end
    end
  end

  // One input transfer; valid stays high afterwards until the next gap or drain.
  task automatic send_item(op_t op, int ra, int rb, int cx = 0, int cy = 0);
    in_item_t it;
    int gap;
    it.opcode = op;
    it.rand_a = RAND_W'(ra);
    it.rand_b = RAND_W'(rb);
    it.cell_x = X_W'(cx);
    it.cell_y = Y_W'(cy);
    if (!quiet && $urandom_range(99) < 14) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), carve_predict(it));
    items_sent++;
  endtask

  // Drop valid and wait until every expected result is in.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= DIM_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_GRID_W) reg_w = val & 63;
    else reg_h = val & 63;
  endtask

  task automatic set_grid(int w, int h);
    drain();
    write_reg(REG_GRID_W, w);
    write_reg(REG_GRID_H, h);
  endtask

  task automatic step_rand();
    send_item(OP_STEP, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
  endtask

  // Reads before any start, empty-frontier step, unknown opcode.
  task automatic test_before_start();
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 15, 15);
    send_item(OP_READ, 0, 0, 31, 31);   // outside the reset-time 16x16 grid
    send_item(OP_STEP, 16'hFFFF, 16'hFFFF);
    send_item(OP_BAD, 16'hFFFF, 16'hFFFF, 31, 31);
  endtask

  // Single cell, clamped sizes, and a register change in the middle of a maze.
  task automatic test_grid_extremes();
    set_grid(1, 1);
    send_item(OP_START, 16'hFFFF, 16'hFFFF);   // maze done at once
    send_item(OP_STEP, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    set_grid(0, 63);                            // clamps to 1 x 32
    send_item(OP_START, 16'hFFFF, 16'hFFFF);
    repeat (3) send_item(OP_STEP, 16'hFFFF, 0);
    send_item(OP_READ, 0, 0, 0, 31);
    set_grid(63, 0);                            // clamps to 32 x 1
    send_item(OP_START, 0, 16'hFFFF);
    send_item(OP_STEP, 0, 16'hFFFF);
    set_grid(2, 2);                             // must not affect this maze
    send_item(OP_STEP, 16'hFFFF, 16'hFFFF);
    send_item(OP_READ, 0, 0, 31, 0);
    send_item(OP_READ, 0, 0, 0, 1);
    send_item(OP_START, 5, 7);                  // now 2 x 2
    repeat (3) send_item(OP_STEP, 3, 1);
    send_item(OP_STEP, 0, 0);                   // frontier empty
  endtask

  // Random mazes of random sizes, mostly small, with reads and noise mixed in.
  task automatic test_random_mazes();
    int w, h, steps, pick;
    while (items_sent < 470) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        w = 32; h = 32;
      end else if (pick < 10) begin
        w = $urandom_range(1) ? 0 : 63;
        h = $urandom_range(1) ? 0 : 63;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      quiet = ($urandom_range(9) == 0);
      set_grid(w, h);
      send_item(OP_START, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
      steps = clamp_size(w, MAX_W) * clamp_size(h, MAX_H);
      if (steps > 120) steps = 120;
      for (int i = 0; i < steps; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_item(OP_BAD, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                    $urandom_range(31), $urandom_range(31));
        end else if (pick < 20) begin
          if ($urandom_range(3) == 0)
            send_item(OP_READ, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                      $urandom_range(31), $urandom_range(31));
          else
            send_item(OP_READ, 0, 0, $urandom_range(act_w - 1), $urandom_range(act_h - 1));
        end else if (pick == 20 && i > 2) begin
          // register change mid-maze, taking effect only at the next start
          set_grid($urandom_range(63), $urandom_range(63));
          step_rand();
        end else begin
          step_rand();
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_before_start();
    test_grid_extremes();
    test_random_mazes();
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
